@@ rtl/rale_pkg.sv @@
// Shared types and constants of the record list engine.
// Used by rale_ctrl, rale_datapath and record_array_list_engine_top.
package rale_pkg;

    localparam int KEY_HEAD_W = 64;
    localparam int KEY_TAIL_W = 8;
    localparam int ID_W       = 64;
    localparam int GRADE_W    = 16;
    localparam int REC_W      = KEY_HEAD_W + KEY_TAIL_W + ID_W + GRADE_W;
    localparam int POS_W      = 8;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic       load;
        logic       shift_up;
        logic       shift_dn;
        logic       put_new;
        logic       cnt_dec;
        logic       scan_rd;
        logic       take_read;
        logic       emit;
        logic       emit_rec;
        logic [1:0] emit_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       pos_ok;
        logic       more;
        logic       pend;
        logic       cmp_valid;
        logic       match;
    } t_dp_stat;

endpackage

@@ rtl/rale_ctrl.sv @@
// Controller of the record list engine: sequences check, shift, scan and response.
// Depends on rale_pkg for command/status types and codes.
module rale_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    output logic                o_done,
    input  rale_pkg::t_dp_stat  i_stat,
    output rale_pkg::t_dp_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_INS   = 3'd2;
    localparam logic [2:0] S_DEL   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_code, n_code;
    logic       r_rec, n_rec;
    logic       r_done, n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= rale_pkg::ST_OK;
            r_rec   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_rec   <= n_rec;
            r_done  <= n_done;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_code  = r_code;
        n_rec   = r_rec;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_rec  = 1'b0;
                n_code = rale_pkg::ST_BADPOS;
                case (i_stat.kind)
                    rale_pkg::KIND_INSERT: begin
                        if (i_stat.full) begin
                            n_code  = rale_pkg::ST_FULL;
                            n_state = S_RESP;
                        end else if (!i_stat.pos_ok) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_INS;
                        end
                    end
                    rale_pkg::KIND_DELETE: begin
                        n_state = i_stat.pos_ok ? S_DEL : S_RESP;
                    end
                    rale_pkg::KIND_READ: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.take_read = 1'b1;
                            n_code          = rale_pkg::ST_OK;
                            n_rec           = 1'b1;
                        end
                        n_state = S_RESP;
                    end
                    default: begin
                        n_state = S_SCAN;
                    end
                endcase
            end
            S_INS: begin
                if (i_stat.more) begin
                    o_cmd.shift_up = 1'b1;
                end else if (!i_stat.pend) begin
                    o_cmd.put_new = 1'b1;
                    n_code        = rale_pkg::ST_OK;
                    n_rec         = 1'b0;
                    n_state       = S_RESP;
                end
            end
            S_DEL: begin
                if (i_stat.more) begin
                    o_cmd.shift_dn = 1'b1;
                end else if (!i_stat.pend) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_code        = rale_pkg::ST_OK;
                    n_rec         = 1'b0;
                    n_state       = S_RESP;
                end
            end
            S_SCAN: begin
                if (i_stat.cmp_valid && i_stat.match) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_rec    = 1'b1;
                    o_cmd.emit_status = rale_pkg::ST_OK;
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_stat.more) begin
                    o_cmd.scan_rd = 1'b1;
                end else begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_status = rale_pkg::ST_NOTFOUND;
                    n_done            = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_RESP: begin
                o_cmd.emit        = 1'b1;
                o_cmd.emit_rec    = r_rec;
                o_cmd.emit_status = r_code;
                n_done            = 1'b1;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

@@ rtl/rale_datapath.sv @@
// Datapath of the record list engine: record memory, count, walk pointer,
// key compare and result registers. Depends on rale_pkg.
module rale_datapath #(
    parameter int LIST_DEPTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rale_pkg::t_dp_cmd                   i_cmd,
    output rale_pkg::t_dp_stat                  o_stat,
    input  logic [1:0]                          i_kind,
    input  logic [rale_pkg::POS_W-1:0]          i_position,
    input  logic [rale_pkg::KEY_HEAD_W-1:0]     i_key_head,
    input  logic [rale_pkg::KEY_TAIL_W-1:0]     i_key_tail,
    input  logic [rale_pkg::ID_W-1:0]           i_record_id,
    input  logic [rale_pkg::GRADE_W-1:0]        i_grade,
    output logic [1:0]                          o_status,
    output logic [rale_pkg::POS_W-1:0]          o_hit_position,
    output logic [rale_pkg::KEY_HEAD_W-1:0]     o_out_key_head,
    output logic [rale_pkg::KEY_TAIL_W-1:0]     o_out_key_tail,
    output logic [rale_pkg::ID_W-1:0]           o_out_record_id,
    output logic [rale_pkg::GRADE_W-1:0]        o_out_grade,
    output logic [rale_pkg::POS_W-1:0]          o_entry_total
);

    localparam int AW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > rale_pkg::POS_W) ? CW : rale_pkg::POS_W;
    localparam int HW   = ((AW + 1) > rale_pkg::POS_W) ? (AW + 1) : rale_pkg::POS_W;
    localparam int RW   = rale_pkg::REC_W;

    logic [RW-1:0] mem [LIST_DEPTH];

    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      r_ptr, n_ptr;
    logic [1:0]                         r_kind;
    logic [rale_pkg::POS_W-1:0]         r_pos;
    logic [rale_pkg::KEY_HEAD_W-1:0]    r_key_head;
    logic [rale_pkg::KEY_TAIL_W-1:0]    r_key_tail;
    logic [rale_pkg::ID_W-1:0]          r_record_id;
    logic [rale_pkg::GRADE_W-1:0]       r_grade;
    logic [RW-1:0]                      r_rdata;
    logic [AW-1:0]                      r_ridx;
    logic [AW-1:0]                      r_waddr;
    logic                               r_pend;
    logic                               r_cmp_valid;

    logic [CMPW-1:0]                    pos_ext, cnt_ext, ptr_ext;
    logic                               rd_en, wr_en;
    logic [AW-1:0]                      rd_addr, wr_addr;
    logic [RW-1:0]                      wr_data;
    logic [HW-1:0]                      hit_w;
    logic [CMPW-1:0]                    total_w;

    assign pos_ext = CMPW'(r_pos);
    assign cnt_ext = CMPW'(r_count);
    assign ptr_ext = CMPW'(r_ptr);

    // status to controller
    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.full      = (cnt_ext == CMPW'(LIST_DEPTH));
        o_stat.pend      = r_pend;
        o_stat.cmp_valid = r_cmp_valid;
        o_stat.match     = (r_rdata[RW-1 -: rale_pkg::KEY_HEAD_W] == r_key_head) &&
                           (r_rdata[RW-rale_pkg::KEY_HEAD_W-1 -: rale_pkg::KEY_TAIL_W]
                            == r_key_tail);
        if (r_kind == rale_pkg::KIND_INSERT) begin
            o_stat.pos_ok = (r_pos != '0) && ((pos_ext - CMPW'(1)) <= cnt_ext);
            o_stat.more   = (ptr_ext >= pos_ext);
        end else begin
            o_stat.pos_ok = (r_pos != '0) && (pos_ext <= cnt_ext);
            o_stat.more   = (r_ptr < r_count);
        end
    end

    // memory port control
    always_comb begin
        rd_en   = i_cmd.shift_up | i_cmd.shift_dn | i_cmd.scan_rd | i_cmd.take_read;
        rd_addr = AW'(r_ptr);
        if (i_cmd.shift_up) begin
            rd_addr = AW'(r_ptr - CW'(1));
        end else if (i_cmd.take_read) begin
            rd_addr = AW'(pos_ext - CMPW'(1));
        end
        wr_en   = r_pend | i_cmd.put_new;
        wr_addr = r_waddr;
        wr_data = r_rdata;
        if (i_cmd.put_new) begin
            wr_addr = AW'(pos_ext - CMPW'(1));
            wr_data = {r_key_head, r_key_tail, r_record_id, r_grade};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
            r_ridx  <= rd_addr;
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.load) begin
            case (i_kind)
                rale_pkg::KIND_INSERT: n_ptr = r_count;
                rale_pkg::KIND_DELETE: n_ptr = CW'(CMPW'(i_position));
                default:               n_ptr = '0;
            endcase
        end else if (i_cmd.shift_up) begin
            n_ptr = r_ptr - CW'(1);
        end else if (i_cmd.shift_dn || i_cmd.scan_rd) begin
            n_ptr = r_ptr + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_kind      <= rale_pkg::KIND_INSERT;
            r_ptr       <= '0;
        end else begin
            r_pend      <= i_cmd.shift_up | i_cmd.shift_dn;
            r_cmp_valid <= i_cmd.scan_rd;
            r_ptr       <= n_ptr;
            if (i_cmd.load) begin
                r_kind <= i_kind;
            end
            if (i_cmd.put_new) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pos       <= i_position;
            r_key_head  <= i_key_head;
            r_key_tail  <= i_key_tail;
            r_record_id <= i_record_id;
            r_grade     <= i_grade;
        end
        if (i_cmd.shift_up) begin
            r_waddr <= AW'(r_ptr);
        end else if (i_cmd.shift_dn) begin
            r_waddr <= AW'(r_ptr - CW'(1));
        end
    end

    assign hit_w   = HW'(r_ridx) + HW'(1);
    assign total_w = cnt_ext;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status      <= i_cmd.emit_status;
            o_entry_total <= total_w[rale_pkg::POS_W-1:0];
            if (i_cmd.emit_rec) begin
                o_hit_position  <= hit_w[rale_pkg::POS_W-1:0];
                {o_out_key_head, o_out_key_tail, o_out_record_id, o_out_grade} <= r_rdata;
            end else begin
                o_hit_position  <= '0;
                o_out_key_head  <= '0;
                o_out_key_tail  <= '0;
                o_out_record_id <= '0;
                o_out_grade     <= '0;
            end
        end
    end

endmodule

@@ rtl/record_array_list_engine_top.sv @@
// Ordered record list of up to LIST_DEPTH entries: insert, delete, read, search.
// A new item is taken when start is high and busy is low; one result per item
// appears for a single cycle with o_done and must be captured then, as it cannot
// be held off. Insert and delete move one record per cycle through the record
// memory's single write port, then write the new record or lower the count once
// the last move has been written. Search compares one record per cycle on its
// read port. No clearing pass.
// Depends on rale_pkg, rale_ctrl and rale_datapath.
module record_array_list_engine_top #(
    parameter int LIST_DEPTH = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_kind,
    input  logic [rale_pkg::POS_W-1:0]          i_position,
    input  logic [rale_pkg::KEY_HEAD_W-1:0]     i_key_head,
    input  logic [rale_pkg::KEY_TAIL_W-1:0]     i_key_tail,
    input  logic [rale_pkg::ID_W-1:0]           i_record_id,
    input  logic [rale_pkg::GRADE_W-1:0]        i_grade,
    output logic                                o_done,
    output logic [1:0]                          o_status,
    output logic [rale_pkg::POS_W-1:0]          o_hit_position,
    output logic [rale_pkg::KEY_HEAD_W-1:0]     o_out_key_head,
    output logic [rale_pkg::KEY_TAIL_W-1:0]     o_out_key_tail,
    output logic [rale_pkg::ID_W-1:0]           o_out_record_id,
    output logic [rale_pkg::GRADE_W-1:0]        o_out_grade,
    output logic [rale_pkg::POS_W-1:0]          o_entry_total
);

    rale_pkg::t_dp_cmd  dp_cmd;
    rale_pkg::t_dp_stat dp_stat;

    rale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    rale_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_key_head      (i_key_head),
        .i_key_tail      (i_key_tail),
        .i_record_id     (i_record_id),
        .i_grade         (i_grade),
        .o_status        (o_status),
        .o_hit_position  (o_hit_position),
        .o_out_key_head  (o_out_key_head),
        .o_out_key_tail  (o_out_key_tail),
        .o_out_record_id (o_out_record_id),
        .o_out_grade     (o_out_grade),
        .o_entry_total   (o_entry_total)
    );

endmodule
